### sv/hdr_pkg.sv
`timescale 1ns / 1ps
// hdr_pkg: shared types and constants of the haptic detent renderer.
// No dependencies; used by haptic_detent_renderer_top.

package hdr_pkg;

  localparam int unsigned MAX_NOTCHES = 5;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_DATA_W   = 32;
  localparam int unsigned OUT_DATA_W  = 24;

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_DAMP_GAIN  = 3'd1,
    REG_HALF_WIDTH = 3'd2,
    REG_CENTER_A   = 3'd3,
    REG_CENTER_B   = 3'd4,
    REG_CENTER_C   = 3'd5,
    REG_CENTER_D   = 3'd6,
    REG_CENTER_E   = 3'd7
  } cfg_idx_e;

  // reset values
  localparam logic [15:0]        PROP_GAIN_RST  = 16'd768;
  localparam logic [15:0]        DAMP_GAIN_RST  = 16'd13;
  localparam logic [14:0]        HALF_WIDTH_RST = 15'd536;
  localparam logic signed [15:0] CENTER_A_RST   = -16'sd2145;
  localparam logic signed [15:0] CENTER_B_RST   = -16'sd1072;
  localparam logic signed [15:0] CENTER_C_RST   = 16'sd0;
  localparam logic signed [15:0] CENTER_D_RST   = 16'sd1072;
  localparam logic signed [15:0] CENTER_E_RST   = 16'sd2145;

  localparam logic signed [15:0] TORQUE_MAX = 16'sh7FFF;
  localparam logic signed [15:0] TORQUE_MIN = -16'sh8000;

  // window match result, carried down the pipe with the sample
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } match_t;

endpackage

### sv/haptic_detent_renderer_top.sv
`timescale 1ns / 1ps
// haptic_detent_renderer_top: detent window search and PD torque law.
// Depends on hdr_pkg.
//
//  channel | ports                      | payload (low bit first)
//  --------+----------------------------+----------------------------------------
//  in      | in_tvalid/in_tready        | in_tdata: angle[15:0], rate[31:16]
//  out     | out_tvalid/out_tready      | out_tdata: torque[15:0], in_notch[16],
//          |                            |   notch_index[19:17], saturated[20], 0
//  cfg     | cfg_we, cfg_index, cfg_data| register write, no read-back
//
//  One transaction per cycle sustained while out_tready is high. A sample taken
//  into stage 1 moves on through stage 2 into the output register of stage 3.
//  Stage 1: window compares and priority pick; stage 2: the two gain multiplies;
//  stage 3: sum, rounding and clipping. Each stage loads when the next one is
//  empty or moving, so bubbles close up and an out_tready stall backs up stage
//  by stage without loss or repeat. rst_n (synchronous) clears the valid bits.

module haptic_detent_renderer_top #(
  parameter int unsigned NOTCH_COUNT = 5  // 1 to 5 notches searched
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [hdr_pkg::IN_DATA_W-1:0]  in_tdata,   // angle, rate
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [hdr_pkg::OUT_DATA_W-1:0] out_tdata,  // torque, in_notch, notch_index, saturated
  // configuration
  input  logic                           cfg_we,
  input  logic [hdr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hdr_pkg::CFG_DATA_W-1:0] cfg_data
);

  // ---------------------------------------------------------------- registers
  logic [15:0]        prop_gain_r;
  logic [15:0]        damp_gain_r;
  logic [14:0]        half_width_r;
  logic signed [15:0] center_r [hdr_pkg::MAX_NOTCHES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= hdr_pkg::PROP_GAIN_RST;
      damp_gain_r  <= hdr_pkg::DAMP_GAIN_RST;
      half_width_r <= hdr_pkg::HALF_WIDTH_RST;
      center_r[0]  <= hdr_pkg::CENTER_A_RST;
      center_r[1]  <= hdr_pkg::CENTER_B_RST;
      center_r[2]  <= hdr_pkg::CENTER_C_RST;
      center_r[3]  <= hdr_pkg::CENTER_D_RST;
      center_r[4]  <= hdr_pkg::CENTER_E_RST;
    end else if (cfg_we) begin
      unique case (hdr_pkg::cfg_idx_e'(cfg_index))
        hdr_pkg::REG_PROP_GAIN:  prop_gain_r  <= cfg_data;
        hdr_pkg::REG_DAMP_GAIN:  damp_gain_r  <= cfg_data;
        hdr_pkg::REG_HALF_WIDTH: half_width_r <= cfg_data[14:0];
        hdr_pkg::REG_CENTER_A:   center_r[0]  <= cfg_data;
        hdr_pkg::REG_CENTER_B:   center_r[1]  <= cfg_data;
        hdr_pkg::REG_CENTER_C:   center_r[2]  <= cfg_data;
        hdr_pkg::REG_CENTER_D:   center_r[3]  <= cfg_data;
        hdr_pkg::REG_CENTER_E:   center_r[4]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- flow control
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  assign rdy3      = !v3_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // ------------------------------------------------- stage 1: window search
  logic signed [15:0] angle_in, rate_in;
  logic signed [16:0] hw_pos, hw_neg;
  logic signed [16:0] diff [hdr_pkg::MAX_NOTCHES];
  hdr_pkg::match_t    match_nxt;
  logic signed [16:0] diff_nxt;

  assign angle_in = in_tdata[15:0];
  assign rate_in  = in_tdata[31:16];
  assign hw_pos   = $signed({2'b00, half_width_r});
  assign hw_neg   = 17'sd0 - hw_pos;

  // diff = centre - angle; inside the open window when -hw < diff < hw
  always_comb begin
    match_nxt = '0;
    diff_nxt  = '0;
    for (int i = 0; i < hdr_pkg::MAX_NOTCHES; i++) begin
      diff[i] = {center_r[i][15], center_r[i]} - {angle_in[15], angle_in};
    end
    // walk down so the lowest matching index is left standing
    for (int i = hdr_pkg::MAX_NOTCHES - 1; i >= 0; i--) begin
      if (i < NOTCH_COUNT && diff[i] < hw_pos && diff[i] > hw_neg) begin
        match_nxt.hit = 1'b1;
        match_nxt.idx = hdr_pkg::IDX_W'(i);
        diff_nxt      = diff[i];
      end
    end
  end

  hdr_pkg::match_t    match1_r;
  logic signed [16:0] diff1_r;
  logic signed [15:0] rate1_r;

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      match1_r <= match_nxt;
      diff1_r  <= diff_nxt;
      rate1_r  <= rate_in;
    end
  end

  // -------------------------------------------------- stage 2: gain products
  logic signed [33:0] p_nxt;   // Q.20
  logic signed [32:0] d_nxt;   // Q.16
  hdr_pkg::match_t    match2_r;
  logic signed [33:0] p2_r;
  logic signed [32:0] d2_r;

  assign p_nxt = $signed({1'b0, prop_gain_r}) * diff1_r;
  assign d_nxt = $signed({1'b0, damp_gain_r}) * rate1_r;

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      match2_r <= match1_r;
      p2_r     <= p_nxt;
      d2_r     <= d_nxt;
    end
  end

  // ------------------------------------- stage 3: sum, round, clip, output
  logic signed [37:0] sum;
  logic signed [29:0] t_full;   // floor((sum) / 256)
  logic signed [15:0] torque_nxt;
  logic               sat_nxt;

  assign sum    = $signed({{4{p2_r[33]}}, p2_r}) - $signed({d2_r[32], d2_r, 4'b0000})
                  + 38'sd128;
  assign t_full = sum[37:8];

  always_comb begin
    torque_nxt = '0;
    sat_nxt    = 1'b0;
    if (match2_r.hit) begin
      priority if (t_full > 30'sd32767) begin
        torque_nxt = hdr_pkg::TORQUE_MAX;
        sat_nxt    = 1'b1;
      end else if (t_full < -30'sd32768) begin
        torque_nxt = hdr_pkg::TORQUE_MIN;
        sat_nxt    = 1'b1;
      end else begin
        torque_nxt = t_full[15:0];
      end
    end
  end

  logic signed [15:0] torque3_r;
  hdr_pkg::match_t    match3_r;
  logic               sat3_r;

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      torque3_r <= torque_nxt;
      match3_r  <= match2_r;
      sat3_r    <= sat_nxt;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = {3'b000, sat3_r, match3_r.idx, match3_r.hit, torque3_r};

  // ---------------------------------------------------------------- checks
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (match3_r.idx < hdr_pkg::IDX_W'(NOTCH_COUNT)))
    else $error("notch index beyond notch count");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !match3_r.hit) |-> (torque3_r == 16'sd0 && !sat3_r &&
                                       match3_r.idx == '0))
    else $error("miss must give zero result");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && sat3_r) |-> (torque3_r == hdr_pkg::TORQUE_MAX ||
                                torque3_r == hdr_pkg::TORQUE_MIN))
    else $error("clipped torque not at a limit");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy2) |=> v2_r)
    else $error("stalled stage 2 lost its item");

  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && !out_tready) |-> !in_tready)
    else $error("full pipe accepted an item");

endmodule

### bench/haptic_detent_renderer_top_tb.sv
`timescale 1ns / 1ps
// haptic_detent_renderer_top_tb: self-checking bench for the detent torque renderer.
// Predicts each torque result in-bench and scores the result stream in order.
// Depends on hdr_pkg and haptic_detent_renderer_top.

module haptic_detent_renderer_top_tb;

  localparam int NOTCHES        = 5;
  localparam int WATCHDOG_LIMIT = 4000;   // exceeds the long hold-off, LONG_HOLD
  localparam int LONG_HOLD      = 400;
  localparam int TAIL_CYCLES    = 8;      // pipe is three deep

  typedef struct {
    logic signed [15:0] angle;
    logic signed [15:0] rate;
  } sample_t;

  typedef struct {
    logic signed [15:0]        torque;
    logic                      in_notch;
    logic [hdr_pkg::IDX_W-1:0] notch_index;
    logic                      saturated;
  } torque_result_t;

  logic                           clk;
  logic                           rst_n     = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [hdr_pkg::IN_DATA_W-1:0]  in_tdata  = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [hdr_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_we    = 1'b0;
  logic [hdr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [hdr_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // shadow copy of the register file
  logic [15:0]        prop_sh = hdr_pkg::PROP_GAIN_RST;
  logic [15:0]        damp_sh = hdr_pkg::DAMP_GAIN_RST;
  logic [14:0]        half_width_sh = hdr_pkg::HALF_WIDTH_RST;
  logic signed [15:0] centre_sh [NOTCHES];

  sample_t        pending_samples [$];
  torque_result_t expected_torques [$];

  int errors        = 0;
  int quiet_cycles  = 0;
  bit calm          = 1'b0;   // no idling on either side
  bit hold_request  = 1'b0;   // ask the receiver for one long hold-off

  haptic_detent_renderer_top #(.NOTCH_COUNT(NOTCHES)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Window search in notch order, then the PD law on the winner.
  // Sum is exact in 64 bits; +128 and an arithmetic shift give round
  // half up to Q3.12, then clip to 16 bits.
  function automatic torque_result_t render_torque(input logic signed [15:0] angle,
                                                   input logic signed [15:0] rate);
    torque_result_t r;
    longint ang, c, hw, sum;
    int i;
    bit found;
    r.torque      = '0;
    r.in_notch    = 1'b0;
    r.notch_index = '0;
    r.saturated   = 1'b0;
    ang   = angle;
    hw    = longint'(half_width_sh);
    found = 1'b0;
    for (i = 0; i < NOTCHES; i++) begin
      c = centre_sh[i];
      if (!found && ang < c + hw && ang > c - hw) begin
        found = 1'b1;
        sum = longint'(prop_sh) * (c - ang) - longint'(damp_sh) * longint'(rate) * 16 + 128;
        sum = sum >>> 8;
        if (sum > 32767) begin
          r.torque    = hdr_pkg::TORQUE_MAX;
          r.saturated = 1'b1;
        end else if (sum < -32768) begin
          r.torque    = hdr_pkg::TORQUE_MIN;
          r.saturated = 1'b1;
        end else begin
          r.torque = sum[15:0];
        end
        r.in_notch    = 1'b1;
        r.notch_index = i[hdr_pkg::IDX_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // one register write per clock; shadow follows at once (block is idle)
  task automatic write_reg(input hdr_pkg::cfg_idx_e idx, input logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      hdr_pkg::REG_PROP_GAIN:  prop_sh = value;
      hdr_pkg::REG_DAMP_GAIN:  damp_sh = value;
      hdr_pkg::REG_HALF_WIDTH: half_width_sh = value[14:0];   // top bit dropped
      default:                 centre_sh[int'(idx) - int'(hdr_pkg::REG_CENTER_A)] = value;
    endcase
  endtask

  task automatic set_config(input logic [15:0] p, input logic [15:0] d,
                            input logic [15:0] hw, input logic [15:0] ca,
                            input logic [15:0] cb, input logic [15:0] cc,
                            input logic [15:0] cd, input logic [15:0] ce);
    write_reg(hdr_pkg::REG_PROP_GAIN, p);
    write_reg(hdr_pkg::REG_DAMP_GAIN, d);
    write_reg(hdr_pkg::REG_HALF_WIDTH, hw);
    write_reg(hdr_pkg::REG_CENTER_A, ca);
    write_reg(hdr_pkg::REG_CENTER_B, cb);
    write_reg(hdr_pkg::REG_CENTER_C, cc);
    write_reg(hdr_pkg::REG_CENTER_D, cd);
    write_reg(hdr_pkg::REG_CENTER_E, ce);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly moderate gains and narrow windows so the torque stays in range;
  // now and then full-scale values. Sometimes two centres coincide.
  task automatic random_config();
    logic [15:0] p, d, hw;
    logic [15:0] c [NOTCHES];
    int k;
    p  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2048));
    d  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
    hw = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3000));
    for (k = 0; k < NOTCHES; k++) c[k] = 16'($urandom);
    if ($urandom_range(0, 3) == 0) c[1] = c[0];
    set_config(p, d, hw, c[0], c[1], c[2], c[3], c[4]);
  endtask

  task automatic push_sample(input int angle, input int rate);
    sample_t s;
    s.angle = angle[15:0];
    s.rate  = rate[15:0];
    pending_samples.push_back(s);
  endtask

  // Most angles land near a notch, just inside or outside its bounds.
  task automatic add_random(input int n);
    int j, k, hw, off, ang, rt;
    hw = int'(half_width_sh);
    for (j = 0; j < n; j++) begin
      if ($urandom_range(0, 9) < 7) begin
        k   = $urandom_range(0, NOTCHES - 1);
        off = int'($urandom_range(0, 2 * hw + 4)) - hw - 2;
        ang = int'(centre_sh[k]) + off;
      end else begin
        ang = $urandom;
      end
      rt = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 128)) - 64 : $urandom;
      push_sample(ang, rt);
    end
  endtask

  // wait until every offered sample has been taken and answered
  task automatic drain();
    do @(posedge clk);
    while (pending_samples.size() != 0 || in_tvalid || expected_torques.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Driver: one sample transaction at a time, random idle bursts between.
  always @(posedge clk) begin : drive_samples
    sample_t s;
    int send_gap;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_torques.push_back(render_torque(in_tdata[15:0], in_tdata[31:16]));
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          s = pending_samples.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {s.rate, s.angle};
          if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 18);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver: score each result transaction, then choose the
  // next ready level (long hold-off, short stall burst, or ready).
  always @(posedge clk) begin : collect_results
    torque_result_t want, got;
    int hold_left, recv_gap;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left = 0;
      recv_gap  = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.torque      = out_tdata[15:0];
        got.in_notch    = out_tdata[16];
        got.notch_index = out_tdata[19:17];
        got.saturated   = out_tdata[20];
        if (expected_torques.size() == 0) begin
          $error("result with no sample pending: torque %0d", got.torque);
          errors++;
        end else begin
          want = expected_torques.pop_front();
          check_field("torque", want.torque, got.torque);
          check_field("in_notch", want.in_notch, got.in_notch);
          check_field("notch_index", want.notch_index, got.notch_index);
          check_field("saturated", want.saturated, got.saturated);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 18);
      end
    end
  end

  // Watchdog: too long without any transaction or register write.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[haptic_detent_renderer_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int n;
    centre_sh[0] = hdr_pkg::CENTER_A_RST;
    centre_sh[1] = hdr_pkg::CENTER_B_RST;
    centre_sh[2] = hdr_pkg::CENTER_C_RST;
    centre_sh[3] = hdr_pkg::CENTER_D_RST;
    centre_sh[4] = hdr_pkg::CENTER_E_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: centres, strict window bounds, gaps between notches,
    // no-match angles and full-scale fields.
    push_sample(0, 0);
    push_sample(-2145, 0);
    push_sample(2145, 32767);
    push_sample(2145, -32768);
    push_sample(-2145 + 536, 0);      // on the bound: outside
    push_sample(-2145 + 535, 0);      // just inside
    push_sample(-2145 - 535, 77);
    push_sample(1072 + 536, 0);       // on the bound of notch d
    push_sample(536, 0);              // bound of c and of d
    push_sample(535, 100);
    push_sample(-535, -100);
    push_sample(-32768, -32768);
    push_sample(32767, 32767);
    push_sample(-32768, 0);
    push_sample(32767, 0);
    drain();

    // Full-scale gains and widest window (top bit of the write dropped).
    // Windows a and c overlap so the lower index must win; clipping both ways.
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000,
               16'h0000, 16'hFFFF);
    push_sample(-32768, 32767);
    push_sample(1, -32768);
    push_sample(0, 0);
    push_sample(-1, 5);
    push_sample(-2, 0);
    push_sample(32767, 32767);
    push_sample(-32768, -32768);
    add_random(30);
    drain();

    // Zero half width: every window is empty.
    set_config(16'd768, 16'd13, 16'd0, 16'h0000, 16'h0001, 16'hFFFF,
               16'h8000, 16'h7FFF);
    add_random(40);
    drain();

    // Zero gains: a hit still reports its notch with zero torque.
    set_config(16'd0, 16'd0, 16'd2000, 16'hF000, 16'hF800, 16'h0000,
               16'h0800, 16'h1000);
    add_random(40);
    drain();

    for (n = 0; n < 6; n++) begin
      random_config();
      add_random(120);
      // the receiver stalls while the sender keeps offering, so the pipe fills
      if (n == 1) hold_request = 1'b1;
      drain();
    end

    // closing stretch at full rate on both sides
    calm = 1'b1;
    random_config();
    add_random(60);
    drain();

    if (errors == 0)
      $display("[haptic_detent_renderer_top] OK");
    else
      $display("[haptic_detent_renderer_top] ERROR");
    $finish;
  end

endmodule
